>>> rtl/apat_pkg.sv
// shared types and constants of the address presence aging table
// no dependencies: used by every other rtl file through scoped names
package apat_pkg;

   // register reset values
   localparam logic [15:0] HOLD_TICKS_RESET = 16'(1200 * 7);
   localparam logic [15:0] INIT_TICKS_RESET = 16'(60 * 7);

   localparam int ADDR_W      = 48;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int REPORT_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_TICKS   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WATCH_ADDR_0 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] NUM_WATCH_REGS   = 3'd4;

   // item kinds
   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FLUSH
   } seq_state_type;

   // what the shared entry unit does to each entry during a scan
   typedef enum logic [2:0] {
      MODE_MATCH,        // frame: reload on address hit
      MODE_AGE_SILENT,   // tick inside the learning period
      MODE_AGE_END_INIT, // tick that ages and ends the learning period
      MODE_END_INIT,     // zero-length learning period ends without ageing
      MODE_AGE_DIFF      // normal tick, report changed entries
   } scan_mode_type;

   // per-entry state seen and produced by the entry unit
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               present;
      logic               reported;
   } entry_state_type;

   // one presence report handed to the report queue
   typedef struct packed {
      logic                    valid;
      logic [REPORT_IDX_W-1:0] entry_index;
      logic                    is_present;
   } report_type;

endpackage

>>> rtl/apat_entry_unit.sv
// shared entry unit: address compare, countdown and presence update of one entry
// depends on apat_pkg
module apat_entry_unit (
   input  apat_pkg::scan_mode_type          mode,
   input  logic [apat_pkg::ADDR_W-1:0]      watch_addr,
   input  logic [apat_pkg::ADDR_W-1:0]      src_addr,
   input  logic [apat_pkg::ADDR_W-1:0]      rcv_addr,
   input  logic [apat_pkg::COUNT_W-1:0]     hold_ticks,
   input  apat_pkg::entry_state_type        cur,
   output apat_pkg::entry_state_type        nxt,
   output logic                             report
);

   logic                         hit;
   logic                         count_nz;
   logic [apat_pkg::COUNT_W-1:0] count_dec;

   // one shared compare pair and one decrementer
   assign hit       = (watch_addr == src_addr) || (watch_addr == rcv_addr);
   assign count_nz  = (cur.count != '0);
   assign count_dec = count_nz ? cur.count - 16'd1 : cur.count;

   always_comb begin
      nxt    = cur;
      report = 1'b0;
      case (mode)
         apat_pkg::MODE_MATCH: begin
            if (hit) begin
               nxt.present = 1'b1;
               nxt.count   = hold_ticks;
            end
         end
         apat_pkg::MODE_AGE_SILENT: begin
            nxt.present = count_nz;
            nxt.count   = count_dec;
         end
         apat_pkg::MODE_AGE_END_INIT: begin
            // ageing then the end-of-init presence taken from the new count
            nxt.count    = count_dec;
            nxt.present  = (count_dec != '0);
            nxt.reported = (count_dec != '0);
            report       = 1'b1;
         end
         apat_pkg::MODE_END_INIT: begin
            nxt.present  = count_nz;
            nxt.reported = count_nz;
            report       = 1'b1;
         end
         apat_pkg::MODE_AGE_DIFF: begin
            nxt.present  = count_nz;
            nxt.count    = count_dec;
            nxt.reported = count_nz;
            report       = (count_nz != cur.reported);
         end
         default: begin
            nxt    = cur;
            report = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/apat_report_queue.sv
// report queue: holds one report back so the final one of a tick can be marked
// depends on apat_pkg
module apat_report_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  apat_pkg::report_type                 step,
   input  logic                                 flush,
   output logic                                 rsp_valid,
   output logic [apat_pkg::REPORT_IDX_W-1:0]    rsp_entry_index,
   output logic                                 rsp_is_present,
   output logic                                 rsp_last_report
);

   apat_pkg::report_type                 pend_ff, pend_in;
   logic                                 valid_ff, valid_in;
   logic                                 last_ff, last_in;
   logic [apat_pkg::REPORT_IDX_W-1:0]    index_ff;
   logic                                 present_ff;

   // a new report pushes the held one out, a flush releases it as the last
   always_comb begin
      pend_in  = pend_ff;
      valid_in = 1'b0;
      last_in  = 1'b0;
      if (flush) begin
         valid_in      = pend_ff.valid;
         last_in       = 1'b1;
         pend_in.valid = 1'b0;
      end else if (step.valid) begin
         valid_in = pend_ff.valid;
         pend_in  = step;
      end
   end

   // held report and output strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      index_ff   <= pend_ff.entry_index;
      present_ff <= pend_ff.is_present;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_entry_index = index_ff;
   assign rsp_is_present  = present_ff;
   assign rsp_last_report = last_ff;

endmodule

>>> rtl/address_presence_aging_table_top.sv
// top level of the address presence aging table: registers, table, sequencer
// depends on apat_pkg, apat_entry_unit and apat_report_queue
//
// usage
// - an item is taken when start is high and busy is low; req_type selects a
//   frame (source and receiver address compared against every watched entry)
//   or an aging tick
// - every item walks the table one entry per cycle through a single shared
//   compare and decrement unit, then passes through the release state that lets
//   the held report out; busy stays high during the walk and the release state
// - a tick gives up to NUM_ENTRIES results on rsp_valid, one cycle each, in
//   ascending entry order; each report is held until the next report of the
//   tick or the release state, so the last one is let out by the release state
//   and flagged by rsp_last_report; a frame and a tick that stays inside the
//   learning period give none
// - results cannot be held off, there is no stall on the result side
// - csr_ready is always high; a write to an unknown index is dropped
// - reset sets the registers to their defaults, every count to the learning
//   length and clears presence; no clearing pass is needed
module address_presence_aging_table_top #(
   parameter int NUM_ENTRIES = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_type,
   input  logic [apat_pkg::ADDR_W-1:0]          req_src_addr,
   input  logic [apat_pkg::ADDR_W-1:0]          req_rcv_addr,
   output logic                                 rsp_valid,
   output logic [apat_pkg::REPORT_IDX_W-1:0]    rsp_entry_index,
   output logic                                 rsp_is_present,
   output logic                                 rsp_last_report,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [apat_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [apat_pkg::ADDR_W-1:0]          csr_data
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   // configuration
   logic [apat_pkg::COUNT_W-1:0]  hold_ticks_ff;
   logic [apat_pkg::ADDR_W-1:0]   watch_ff [NUM_ENTRIES];

   // table and learning period state
   logic [apat_pkg::COUNT_W-1:0]  count_ff    [NUM_ENTRIES];
   logic                          present_ff  [NUM_ENTRIES];
   logic                          reported_ff [NUM_ENTRIES];
   logic [apat_pkg::COUNT_W-1:0]  init_rem_ff, init_rem_in;
   logic                          init_done_ff, init_done_in;

   // sequencer
   apat_pkg::seq_state_type       state_ff, state_in;
   apat_pkg::scan_mode_type       mode_ff, mode_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [apat_pkg::ADDR_W-1:0]   src_ff, rcv_ff;

   logic                          accept;
   logic                          csr_wr;
   logic                          csr_is_watch;
   logic [apat_pkg::CSR_INDEX_W-1:0] watch_sel;
   apat_pkg::entry_state_type     cur_entry, nxt_entry;
   logic                          unit_report;
   apat_pkg::report_type          step;
   logic                          flush;

   assign csr_ready    = 1'b1;
   assign csr_wr       = csr_valid & csr_ready;
   assign watch_sel    = csr_index - apat_pkg::CSR_WATCH_ADDR_0;
   assign csr_is_watch = (csr_index >= apat_pkg::CSR_WATCH_ADDR_0) &&
                         (watch_sel < apat_pkg::NUM_WATCH_REGS);
   assign busy         = (state_ff != apat_pkg::SEQ_IDLE);
   assign accept       = start & ~busy;

   // configuration registers; the learning length only acts through the reload
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= apat_pkg::HOLD_TICKS_RESET;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            watch_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         if (csr_index == apat_pkg::CSR_HOLD_TICKS) begin
            hold_ticks_ff <= csr_data[apat_pkg::COUNT_W-1:0];
         end
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (csr_is_watch && (watch_sel == apat_pkg::CSR_INDEX_W'(i))) begin
               watch_ff[i] <= csr_data;
            end
         end
      end
   end

   // sequencer next state and scan mode chosen when an item is taken
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      init_rem_in  = init_rem_ff;
      init_done_in = init_done_ff;
      flush        = 1'b0;
      case (state_ff)
         apat_pkg::SEQ_IDLE: begin
            idx_in = '0;
            if (accept) begin
               state_in = apat_pkg::SEQ_SCAN;
               if (req_type == apat_pkg::REQ_FRAME) begin
                  mode_in = apat_pkg::MODE_MATCH;
               end else if (init_done_ff) begin
                  mode_in = apat_pkg::MODE_AGE_DIFF;
               end else if (init_rem_ff == '0) begin
                  mode_in      = apat_pkg::MODE_END_INIT;
                  init_done_in = 1'b1;
               end else if (init_rem_ff == 16'd1) begin
                  mode_in      = apat_pkg::MODE_AGE_END_INIT;
                  init_rem_in  = '0;
                  init_done_in = 1'b1;
               end else begin
                  mode_in     = apat_pkg::MODE_AGE_SILENT;
                  init_rem_in = init_rem_ff - 16'd1;
               end
            end
         end
         apat_pkg::SEQ_SCAN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = apat_pkg::SEQ_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         apat_pkg::SEQ_FLUSH: begin
            flush    = 1'b1;
            state_in = apat_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = apat_pkg::SEQ_IDLE;
         end
      endcase
   end

   // sequencer and learning period registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apat_pkg::SEQ_IDLE;
         mode_ff      <= apat_pkg::MODE_MATCH;
         idx_ff       <= '0;
         init_rem_ff  <= apat_pkg::INIT_TICKS_RESET;
         init_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         init_done_ff <= init_done_in;
         if (csr_wr && (csr_index == apat_pkg::CSR_INIT_TICKS) && !init_done_ff) begin
            init_rem_ff <= csr_data[apat_pkg::COUNT_W-1:0];
         end else begin
            init_rem_ff <= init_rem_in;
         end
      end
   end

   // addresses of the item in progress
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= req_src_addr;
         rcv_ff <= req_rcv_addr;
      end
   end

   // entry selected by the scan counter
   assign cur_entry.count    = count_ff[idx_ff];
   assign cur_entry.present  = present_ff[idx_ff];
   assign cur_entry.reported = reported_ff[idx_ff];

   apat_entry_unit u_entry_unit (
      .mode       (mode_ff),
      .watch_addr (watch_ff[idx_ff]),
      .src_addr   (src_ff),
      .rcv_addr   (rcv_ff),
      .hold_ticks (hold_ticks_ff),
      .cur        (cur_entry),
      .nxt        (nxt_entry),
      .report     (unit_report)
   );

   // table write back, one entry per scan cycle; init reload on a csr write before the learning period ends
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            count_ff[i]    <= apat_pkg::INIT_TICKS_RESET;
            present_ff[i]  <= 1'b0;
            reported_ff[i] <= 1'b0;
         end
      end else if (csr_wr && (csr_index == apat_pkg::CSR_INIT_TICKS) && !init_done_ff) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            count_ff[i] <= csr_data[apat_pkg::COUNT_W-1:0];
         end
      end else if (state_ff == apat_pkg::SEQ_SCAN) begin
         count_ff[idx_ff]    <= nxt_entry.count;
         present_ff[idx_ff]  <= nxt_entry.present;
         reported_ff[idx_ff] <= nxt_entry.reported;
      end
   end

   // report of the scanned entry, index masked to the result width
   assign step.valid       = (state_ff == apat_pkg::SEQ_SCAN) && unit_report;
   assign step.entry_index = apat_pkg::REPORT_IDX_W'(idx_ff);
   assign step.is_present  = nxt_entry.present;

   apat_report_queue u_report_queue (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .flush           (flush),
      .rsp_valid       (rsp_valid),
      .rsp_entry_index (rsp_entry_index),
      .rsp_is_present  (rsp_is_present),
      .rsp_last_report (rsp_last_report)
   );

endmodule
